// File: rtl/pmdg_pkg.sv
package pmdg_pkg;

    // Grid geometry and number formats.
    localparam int FreqCount    = 16;
    localparam int AugFactor    = 2;
    localparam int PositionBits = 16;
    localparam int GridSide     = AugFactor * FreqCount;
    localparam int IdxBits      = $clog2(GridSide);
    localparam int CellTotal    = GridSide * GridSide * GridSide;
    localparam int AddrBits     = 3 * IdxBits;
    localparam int PosW         = 17;
    localparam int OffW         = 18;
    localparam int ProdW        = 2 * OffW;
    localparam int SumW         = 48;
    localparam int CountW       = 32;

    typedef enum logic [1:0] {
        KIND_DEPOSIT = 2'd0,
        KIND_READ    = 2'd1,
        KIND_CLEAR   = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_WRITE,
        ST_DONE
    } state_t;

    // One memory word: count and nine moment sums (x, y, z, xx, yy, zz, xy, xz, yz).
    typedef struct packed {
        logic signed [CountW-1:0]     count;
        logic        [8:0][SumW-1:0]  sums;
    } cell_t;

    typedef struct packed {
        logic                   bad;
        logic [IdxBits-1:0]     idx;
        logic signed [OffW-1:0] off;
    } loc_t;

    // Rounds one axis to the nearest cell and measures the offset from it.
    // The rounding sum keeps one spare bit so that the largest positions
    // still show up as beyond the grid.
    function automatic loc_t locate(input logic [PosW-1:0] pos);
        logic [PosW+IdxBits+1:0]    t;
        logic [PosW+IdxBits-PositionBits:0] i;
        logic [PosW+IdxBits-1:0]    scaled;
        logic [IdxBits-1:0]         idx;
        logic signed [PosW+IdxBits:0] diff;
        loc_t                       r;
        scaled = {pos, {IdxBits{1'b0}}};
        t      = {1'b0, scaled, 1'b0} + (PosW+IdxBits+2)'(1 << PositionBits);
        i      = t[PosW+IdxBits+1:PositionBits+1];
        idx    = (i >= (PosW+IdxBits-PositionBits+1)'(GridSide))
                 ? IdxBits'(GridSide - 1) : i[IdxBits-1:0];
        diff   = $signed({1'b0, scaled})
                 - $signed((PosW+IdxBits+1)'({idx, {PositionBits{1'b0}}}));
        r.bad  = (i > (PosW+IdxBits-PositionBits+1)'(GridSide));
        r.idx  = idx;
        r.off  = diff[OffW-1:0];
        return r;
    endfunction

    // Saturating 48-bit add.
    function automatic logic [SumW-1:0] sat48(input logic [SumW-1:0] a,
                                              input logic [SumW-1:0] b);
        logic signed [SumW:0] s;
        s = $signed({a[SumW-1], a}) + $signed({b[SumW-1], b});
        if (s[SumW] != s[SumW-1])
            return s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
        return s[SumW-1:0];
    endfunction

endpackage

// File: rtl/particle_moment_deposit_grid_top.sv
// Particle moment deposition onto a 32x32x32 grid.
// Input channel (in_valid/in_ready) carries one request: a particle deposit,
// a cell read, or a cell read-and-clear. Output channel (out_valid/out_ready)
// returns exactly one result per request: status plus the ten cell sums
// (sums are zero for deposits and for failed requests).
// Each request is handled alone in a read-modify-write of one wide memory
// word: accept, read issue, multiply, write back, result. A request that
// touches the memory passes through the read, multiply and write-back steps
// before its result; a dropped particle, a bad read or an unused kind goes
// from acceptance straight to the result step. The next request is accepted
// the cycle after the result is loaded into the output register, so it may
// enter while that result still waits. No new request enters while one is
// in its steps, and memory requests take longer, held by the memory read
// and the offset multipliers ahead of the write back.
// After reset a clearing pass writes zero to all 32768 cells, one per cycle;
// in_ready stays low throughout the pass.
// When the receiver stalls, the result holds in the output register and a
// finished follow-on request waits in its last step until the register frees.
module particle_moment_deposit_grid_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          kind,
    input  logic                                negative,
    input  logic [16:0]                         pos_x,
    input  logic [16:0]                         pos_y,
    input  logic [16:0]                         pos_z,
    input  logic [4:0]                          cell_x,
    input  logic [4:0]                          cell_y,
    input  logic [4:0]                          cell_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                status,
    output logic signed [31:0]                  count_sum,
    output logic signed [47:0]                  sum_dx,
    output logic signed [47:0]                  sum_dy,
    output logic signed [47:0]                  sum_dz,
    output logic signed [47:0]                  sum_dxx,
    output logic signed [47:0]                  sum_dyy,
    output logic signed [47:0]                  sum_dzz,
    output logic signed [47:0]                  sum_dxy,
    output logic signed [47:0]                  sum_dxz,
    output logic signed [47:0]                  sum_dyz
);
    import pmdg_pkg::*;

    state_t state_reg, state_next;
    logic [AddrBits-1:0]      clr_cnt_reg;
    logic [AddrBits-1:0]      addr_reg;
    kind_t                    kind_reg;
    logic                     neg_reg;
    logic signed [OffW-1:0]   dx_reg, dy_reg, dz_reg;
    logic [5:0][ProdW-1:0]    prod_reg;
    cell_t                    mem [CellTotal];
    cell_t                    mem_q_reg;
    cell_t                    pend_reg;
    logic                     pend_status_reg;
    cell_t                    out_reg;
    logic                     out_status_reg;
    logic                     out_valid_reg;

    loc_t lx, ly, lz;
    logic accept, load_out;
    logic cell_ok;
    logic mem_we;
    logic [AddrBits-1:0] mem_waddr;
    cell_t mem_wdata, upd;
    logic [8:0][SumW-1:0] delta;
    logic signed [CountW:0] cnt_sum;

    assign lx = locate(pos_x);
    assign ly = locate(pos_y);
    assign lz = locate(pos_z);

    // A read or read-and-clear names a cell inside the grid.
    assign cell_ok = ({1'b0, cell_x} < 6'(GridSide)) && ({1'b0, cell_y} < 6'(GridSide))
                     && ({1'b0, cell_z} < 6'(GridSide));

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // State machine.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == '1) state_next = ST_IDLE;
            ST_IDLE:
                if (accept)
                begin
                    state_next = ST_DONE;
                    if (kind_t'(kind) == KIND_DEPOSIT && !(lx.bad || ly.bad || lz.bad))
                        state_next = ST_READ;
                    if ((kind_t'(kind) == KIND_READ || kind_t'(kind) == KIND_CLEAR)
                        && cell_ok)
                        state_next = ST_READ;
                end
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  if (load_out) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Clearing pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (state_reg == ST_CLEAR)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg        <= kind_t'(kind);
            neg_reg         <= negative;
            dx_reg          <= lx.off;
            dy_reg          <= ly.off;
            dz_reg          <= lz.off;
            pend_reg        <= '0;
            pend_status_reg <= 1'b0;
            if (kind_t'(kind) == KIND_DEPOSIT)
            begin
                addr_reg        <= {lx.idx, ly.idx, lz.idx};
                pend_status_reg <= lx.bad || ly.bad || lz.bad;
            end
            else
            begin
                addr_reg <= {cell_x[IdxBits-1:0], cell_y[IdxBits-1:0],
                             cell_z[IdxBits-1:0]};
                if (kind_t'(kind) != KIND_NONE)
                    pend_status_reg <= !cell_ok;
            end
        end
        else if (state_reg == ST_WRITE && kind_reg != KIND_DEPOSIT)
            pend_reg <= mem_q_reg;
    end

    // Offset products, registered ahead of the write back.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg[0] <= ProdW'(dx_reg * dx_reg);
            prod_reg[1] <= ProdW'(dy_reg * dy_reg);
            prod_reg[2] <= ProdW'(dz_reg * dz_reg);
            prod_reg[3] <= ProdW'(dx_reg * dy_reg);
            prod_reg[4] <= ProdW'(dx_reg * dz_reg);
            prod_reg[5] <= ProdW'(dy_reg * dz_reg);
        end
    end

    // Saturating update of the cell word.
    always_comb
    begin
        delta[0] = SumW'(dx_reg);
        delta[1] = SumW'(dy_reg);
        delta[2] = SumW'(dz_reg);
        for (int k = 0; k < 6; k++)
            delta[3+k] = SumW'($signed(prod_reg[k]));
        for (int k = 0; k < 9; k++)
        begin
            if (neg_reg)
                delta[k] = -delta[k];
            upd.sums[k] = sat48(mem_q_reg.sums[k], delta[k]);
        end
        cnt_sum = $signed({mem_q_reg.count[CountW-1], mem_q_reg.count})
                  + (neg_reg ? -(CountW+1)'(1) : (CountW+1)'(1));
        if (cnt_sum[CountW] != cnt_sum[CountW-1])
            upd.count = cnt_sum[CountW] ? {1'b1, {(CountW-1){1'b0}}}
                                        : {1'b0, {(CountW-1){1'b1}}};
        else
            upd.count = cnt_sum[CountW-1:0];
    end

    // Memory write port selection.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (state_reg == ST_WRITE)
        begin
            if (kind_reg == KIND_DEPOSIT)
            begin
                mem_we    = 1'b1;
                mem_wdata = upd;
            end
            else if (kind_reg == KIND_CLEAR)
                mem_we = 1'b1;
        end
    end

    // Cell memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
            mem_q_reg <= mem[addr_reg];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg        <= pend_reg;
            out_status_reg <= pend_status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign count_sum = out_reg.count;
    assign sum_dx    = out_reg.sums[0];
    assign sum_dy    = out_reg.sums[1];
    assign sum_dz    = out_reg.sums[2];
    assign sum_dxx   = out_reg.sums[3];
    assign sum_dyy   = out_reg.sums[4];
    assign sum_dzz   = out_reg.sums[5];
    assign sum_dxy   = out_reg.sums[6];
    assign sum_dxz   = out_reg.sums[7];
    assign sum_dyz   = out_reg.sums[8];

endmodule

// File: rtl/pmdg_checker.sv
module pmdg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               status,
    input logic signed [31:0] count_sum,
    input logic signed [47:0] sum_dx
);

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count_sum) && $stable(sum_dx))
        else $error("stalled result changed");

    // A failed request carries zero sums.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> count_sum == 0 && sum_dx == 0)
        else $error("failed request returned nonzero sums");

    // One request at a time: ready drops after an acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request accepted while busy");

endmodule

bind particle_moment_deposit_grid_top pmdg_checker u_pmdg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count_sum (count_sum),
    .sum_dx    (sum_dx)
);
